[design/dsst_pkg.sv]
// ----------------------------------------------------------------------------
// dsst_pkg
// Shared widths, constants and codes of the decaying strength signature table.
// ----------------------------------------------------------------------------
package dsst_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam int unsigned ACT_W  = 2;
  localparam int unsigned SIG_W  = 64;
  localparam int unsigned CONF_W = 33;
  localparam int unsigned STR_W  = 36;
  localparam int unsigned OUTC_W = 3;

  localparam logic [STR_W-1:0] DECAY_STEP   = STR_W'(64'd1 << 25);
  localparam logic [STR_W-1:0] STRENGTH_MAX = STR_W'(64'd8 << 32);

  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  typedef enum logic [OUTC_W-1:0] {
    OUTC_HIT     = 3'd0,
    OUTC_INSERT  = 3'd1,
    OUTC_REPLACE = 3'd2,
    OUTC_QUERY   = 3'd3,
    OUTC_CLEAR   = 3'd4
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

[design/dsst_if.sv]
// ----------------------------------------------------------------------------
// dsst_in_if / dsst_out_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface dsst_in_if;
  import dsst_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [SIG_W-1:0]  signature;
  logic [CONF_W-1:0] confidence;

  modport source (output valid, action, signature, confidence, input ready);
  modport sink   (input valid, action, signature, confidence, output ready);
endinterface

interface dsst_out_if;
  import dsst_pkg::*;

  logic              valid;
  logic              ready;
  logic [STR_W-1:0]  prior_strength;
  logic [STR_W-1:0]  new_strength;
  logic [OUTC_W-1:0] outcome;

  modport source (output valid, prior_strength, new_strength, outcome, input ready);
  modport sink   (input valid, prior_strength, new_strength, outcome, output ready);
endinterface

[design/dsst_ram.sv]
// ----------------------------------------------------------------------------
// dsst_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module dsst_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/decaying_strength_signature_table.sv]
// A request is accepted only while idle; the used entries are then scanned one per
// cycle, and the result is registered once the scan ends (no scan for an empty table).
// No new request is taken until the result of the last one has been registered;
// a result held back by the receiver stalls the next item.
// Reset clears the entry count and the handshake state; the memories are not
// cleared, since no entry at or above the count is ever read.
// ----------------------------------------------------------------------------
// decaying_strength_signature_table
// Signature table with aging strengths: lookup, decay, reinforce, replace and clear.
// ----------------------------------------------------------------------------
module decaying_strength_signature_table #(
  parameter int unsigned TABLE_ENTRIES = dsst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dsst_in_if.sink    in_chan,
  dsst_out_if.source out_chan
);
  import dsst_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  state_t            state_r, state_nxt;
  logic [ACT_W-1:0]  act_r;
  logic [SIG_W-1:0]  key_r;
  logic [CONF_W-1:0] conf_r;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     pend_idx_r;
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     hit_idx_r;
  logic [STR_W-1:0]  prior_r;
  logic [STR_W-1:0]  hit_dec_r;
  logic [STR_W-1:0]  min_r;
  logic [IW-1:0]     min_idx_r;
  logic              out_valid_r, out_valid_nxt;
  logic [STR_W-1:0]  out_prior_r;
  logic [STR_W-1:0]  out_new_r;
  logic [OUTC_W-1:0] out_outc_r;

  logic              in_fire;
  logic              rd_en;
  logic [SIG_W-1:0]  sig_rdata;
  logic [STR_W-1:0]  str_rdata;
  logic [STR_W-1:0]  dec;
  logic              scan_match;
  logic              scan_done;
  logic              out_free;
  logic              fin_fire;
  logic              full;
  logic [STR_W:0]    reinf_sum;
  logic [STR_W-1:0]  reinf;
  logic [STR_W-1:0]  fresh;
  logic [STR_W-1:0]  prior_res;
  logic [STR_W-1:0]  new_res;
  outcome_t          outc_res;
  logic              str_we;
  logic [IW-1:0]     str_waddr;
  logic [STR_W-1:0]  str_wdata;
  logic              sig_we;
  logic [IW-1:0]     fin_slot;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign fin_fire       = (state_r == S_FINISH) && out_free;
  assign full           = (used_r == CW'(TABLE_ENTRIES));

  assign rd_en      = (state_r == S_SCAN) && (rd_idx_r < used_r);
  assign dec        = (str_rdata > DECAY_STEP) ? (str_rdata - DECAY_STEP) : '0;
  assign scan_match = pend_r && !hit_r && (sig_rdata == key_r);
  assign scan_done  = pend_r && ((CW'(pend_idx_r) + CW'(1)) == used_r);

  assign reinf_sum = {1'b0, hit_dec_r} + (STR_W + 1)'(conf_r >> 4);
  assign reinf     = (reinf_sum > {1'b0, STRENGTH_MAX}) ? STRENGTH_MAX
                                                        : reinf_sum[STR_W-1:0];
  assign fresh     = STR_W'(conf_r >> 3);
  assign fin_slot  = full ? min_idx_r : used_r[IW-1:0];
  assign prior_res = hit_r ? prior_r : '0;

  always_comb begin
    new_res  = prior_res;
    outc_res = OUTC_QUERY;
    used_nxt = used_r;
    sig_we   = 1'b0;
    unique case (act_r)
      ACT_CLEAR: begin
        new_res  = '0;
        outc_res = OUTC_CLEAR;
        if (fin_fire) begin
          used_nxt = '0;
        end
      end
      ACT_UPDATE: begin
        if (hit_r) begin
          new_res  = reinf;
          outc_res = OUTC_HIT;
        end else begin
          new_res  = fresh;
          outc_res = full ? OUTC_REPLACE : OUTC_INSERT;
          sig_we   = fin_fire;
          if (fin_fire && !full) begin
            used_nxt = used_r + CW'(1);
          end
        end
      end
      default: begin
        new_res  = prior_res;
        outc_res = OUTC_QUERY;
      end
    endcase
  end

  always_comb begin
    str_we    = 1'b0;
    str_waddr = pend_idx_r;
    str_wdata = dec;
    if (pend_r && (act_r == ACT_UPDATE)) begin
      str_we = 1'b1;
    end else if (fin_fire && (act_r == ACT_UPDATE)) begin
      str_we    = 1'b1;
      str_waddr = hit_r ? hit_idx_r : fin_slot;
      str_wdata = new_res;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = rd_en;
    hit_nxt       = hit_r || scan_match;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rd_idx_nxt = '0;
          hit_nxt    = 1'b0;
          state_nxt  = (used_r == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_chan.action;
      key_r  <= in_chan.signature;
      conf_r <= in_chan.confidence;
    end
    if (rd_en) begin
      pend_idx_r <= rd_idx_r[IW-1:0];
    end
    if (scan_match) begin
      hit_idx_r <= pend_idx_r;
      prior_r   <= str_rdata;
      hit_dec_r <= dec;
    end
    if (pend_r && ((pend_idx_r == '0) || (dec < min_r))) begin
      min_r     <= dec;
      min_idx_r <= pend_idx_r;
    end
    if (fin_fire) begin
      out_prior_r <= prior_res;
      out_new_r   <= new_res;
      out_outc_r  <= outc_res;
    end
  end

  dsst_ram #(
    .WIDTH(SIG_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_sig_ram (
    .clk   (clk),
    .we    (sig_we),
    .waddr (fin_slot),
    .wdata (key_r),
    .re    (rd_en),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (sig_rdata)
  );

  dsst_ram #(
    .WIDTH(STR_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_str_ram (
    .clk   (clk),
    .we    (str_we),
    .waddr (str_waddr),
    .wdata (str_wdata),
    .re    (rd_en),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (str_rdata)
  );

  assign out_chan.valid          = out_valid_r;
  assign out_chan.prior_strength = out_prior_r;
  assign out_chan.new_strength   = out_new_r;
  assign out_chan.outcome        = out_outc_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_ENTRIES))
    else $error("Entry count exceeds the table depth.");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (str_we && rd_en) |-> (str_waddr != rd_idx_r[IW-1:0]))
    else $error("Strength write collides with a read of the same entry.");

  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (CW'(pend_idx_r) < used_r))
    else $error("Scanned entry lies beyond the used entries.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != S_IDLE))
    else $error("Block returned to idle in the cycle after a transaction.");

  a_scan_has_reads: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && !pend_r) |-> rd_en)
    else $error("Scan stalled with no read outstanding.");
`endif

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives request transactions into the decaying strength signature table and
// predicts each result from a local copy of the table. Every result
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import dsst_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 2 * (TABLE_ENTRIES_DEF + 3);

  typedef struct packed {
    logic [STR_W-1:0] prior;
    logic [STR_W-1:0] after;
    outcome_t         outcome;
  } strength_report_t;

  logic clk;
  logic rst_n;

  dsst_in_if  in_chan ();
  dsst_out_if out_chan ();

  decaying_strength_signature_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [SIG_W-1:0] tab_sig [TABLE_ENTRIES_DEF];
  logic [STR_W-1:0] tab_strength [TABLE_ENTRIES_DEF];
  int               tab_count;

  strength_report_t pending_reports[$];
  strength_report_t oldest;
  logic [SIG_W-1:0] sig_pool [POOL_SIZE];
  int unsigned      fail_count;
  int unsigned      cycle_count;
  int unsigned      rx_hold_cycles;
  bit               rx_calm;
  bit               tx_calm;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic strength_report_t apply_request(input logic [ACT_W-1:0] act,
                                                     input logic [SIG_W-1:0] sig,
                                                     input logic [CONF_W-1:0] conf);
    strength_report_t rep;
    int               hit;
    int               slot;
    logic [STR_W:0]   sum;
    logic [STR_W-1:0] fresh;
    hit = -1;
    for (int i = 0; i < tab_count; i++) begin
      if (hit < 0 && tab_sig[i] == sig) begin
        hit = i;
      end
    end
    rep.prior   = (hit >= 0) ? tab_strength[hit] : '0;
    rep.after   = rep.prior;
    rep.outcome = OUTC_QUERY;
    case (act)
      ACT_CLEAR: begin
        tab_count   = 0;
        rep.after   = '0;
        rep.outcome = OUTC_CLEAR;
      end
      ACT_UPDATE: begin
        for (int i = 0; i < tab_count; i++) begin
          tab_strength[i] = (tab_strength[i] > DECAY_STEP) ? tab_strength[i] - DECAY_STEP : '0;
        end
        if (hit >= 0) begin
          sum = {1'b0, tab_strength[hit]} + (STR_W + 1)'(conf >> 4);
          if (sum > {1'b0, STRENGTH_MAX}) begin
            sum = {1'b0, STRENGTH_MAX};
          end
          tab_strength[hit] = sum[STR_W-1:0];
          rep.after   = sum[STR_W-1:0];
          rep.outcome = OUTC_HIT;
        end else begin
          fresh = STR_W'(conf >> 3);
          if (tab_count < TABLE_ENTRIES_DEF) begin
            slot = tab_count;
            tab_count++;
            rep.outcome = OUTC_INSERT;
          end else begin
            slot = 0;
            for (int i = 1; i < TABLE_ENTRIES_DEF; i++) begin
              if (tab_strength[i] < tab_strength[slot]) begin
                slot = i;
              end
            end
            rep.outcome = OUTC_REPLACE;
          end
          tab_sig[slot]      = sig;
          tab_strength[slot] = fresh;
          rep.after          = fresh;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [SIG_W-1:0] sig,
                              input logic [CONF_W-1:0] conf);
    int unsigned      gap;
    strength_report_t rep;
    gap = tx_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.signature  <= sig;
    in_chan.confidence <= conf;
    do @(posedge clk); while (!in_chan.ready);
    rep = apply_request(act, sig, conf);
    pending_reports = {pending_reports, rep};
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned      pick;
    logic [ACT_W-1:0] act;
    logic [SIG_W-1:0] sig;
    logic [CONF_W-1:0] conf;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      act = ACT_CLEAR;
    end else if (pick < 5) begin
      act = ACT_SPARE;
    end else if (pick < 30) begin
      act = ACT_QUERY;
    end else begin
      act = ACT_UPDATE;
    end
    if ($urandom_range(0, 99) < 85) begin
      sig = sig_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      sig = {$urandom, $urandom};
    end
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      conf = {1'($urandom_range(0, 1)), $urandom};
    end else if (pick < 9) begin
      conf = {1'b0, $urandom};
    end else begin
      conf = 33'h1_0000_0000;
    end
    send_request(act, sig, conf);
  endtask

  task automatic test_directed();
    logic [SIG_W-1:0] base;
    base = {$urandom, $urandom};
    send_request(ACT_QUERY, base, '0);
    send_request(ACT_CLEAR, base, '0);
    send_request(ACT_SPARE, base, '1);
    send_request(ACT_UPDATE, '0, '0);
    send_request(ACT_UPDATE, '1, 33'h0_1000_0000);
    send_request(ACT_UPDATE, base, 33'h0_0800_0000);
    send_request(ACT_UPDATE, base ^ 64'h1, 33'h1_0000_0000);
    send_request(ACT_UPDATE, base ^ 64'h2, '1);
    for (int i = 3; i < 14; i++) begin
      send_request(ACT_UPDATE, base ^ SIG_W'(i), {1'($urandom_range(0, 1)), $urandom});
    end
    send_request(ACT_UPDATE, base ^ 64'h2, 33'h1_0000_0000);
    send_request(ACT_QUERY, base ^ 64'h2, '0);
    send_request(ACT_SPARE, '1, '0);
    send_request(ACT_UPDATE, ~base, 33'h0_4000_0000);
    send_request(ACT_CLEAR, base ^ 64'h1, '0);
    send_request(ACT_QUERY, base ^ 64'h1, '0);
    wait_drained();
  endtask

  task automatic test_saturation();
    logic [SIG_W-1:0] sig;
    sig = {$urandom, $urandom};
    send_request(ACT_CLEAR, sig, '0);
    for (int i = 0; i < 80; i++) begin
      send_request(ACT_UPDATE, sig, '1);
      if (i % 10 == 9) begin
        send_request(ACT_QUERY, sig, '0);
      end
    end
    send_request(ACT_UPDATE, sig, 33'h1_0000_0000);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit calm);
    tx_calm = calm;
    rx_calm = calm;
    for (int i = 0; i < count; i++) begin
      random_request();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  task automatic test_backpressure();
    rx_hold_cycles = 200;
    for (int i = 0; i < 40; i++) begin
      random_request();
    end
    wait_drained();
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 8; i++) begin
        random_request();
      end
      wait_drained();
    end
  endtask

  initial begin : receiver
    int unsigned stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_calm ? 0 : $urandom_range(0, 3);
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected result: expected none, got prior %0h new %0h outcome %0d",
                 $time, out_chan.prior_strength, out_chan.new_strength, out_chan.outcome);
        fail_count++;
      end else begin
        oldest = pending_reports.pop_front();
        if (out_chan.prior_strength !== oldest.prior) begin
          $display("%0t prior_strength: expected %0h, got %0h",
                   $time, oldest.prior, out_chan.prior_strength);
          fail_count++;
        end
        if (out_chan.new_strength !== oldest.after) begin
          $display("%0t new_strength: expected %0h, got %0h",
                   $time, oldest.after, out_chan.new_strength);
          fail_count++;
        end
        if (out_chan.outcome !== oldest.outcome) begin
          $display("%0t outcome: expected %0d, got %0d",
                   $time, oldest.outcome, out_chan.outcome);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("decaying_strength_signature_table: mismatch");
      $finish;
    end
  end

  initial begin
    fail_count     = 0;
    cycle_count    = 0;
    rx_hold_cycles = 0;
    rx_calm        = 1'b0;
    tx_calm        = 1'b0;
    tab_count      = 0;
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.action     <= ACT_UPDATE;
    in_chan.signature  <= '0;
    in_chan.confidence <= '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      sig_pool[i] = {$urandom, $urandom};
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_saturation();
    test_random_traffic(250, 1'b0);
    test_random_traffic(120, 1'b1);
    test_backpressure();
    test_drain_pause();
    test_random_traffic(120, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("decaying_strength_signature_table: match");
    end else begin
      $display("decaying_strength_signature_table: mismatch");
    end
    $finish;
  end

endmodule
